FILE: rtl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, constants and the field label table for the RMC labeler.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    // Character codes and register reset values
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] KEY_RESET     = 8'd144;
    localparam logic [7:0] END_RESET     = 8'd13;

    // Label table shape
    localparam int ROM_LABELS        = 11;
    localparam int LABEL_COUNT_DEF   = 11;
    localparam int LABEL_MAX_LEN     = 22;
    localparam int LBL_IDX_W         = 4;
    localparam int LBL_POS_W         = 5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SENTENCE_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE     = 2'd1;

    typedef enum logic
    {
        ST_READY,
        ST_LABEL
    } nrmc_state_t;

    // Commands from controller to datapath
    typedef struct packed
    {
        logic accept;
        logic load_echo;
        logic load_label;
    } nrmc_cmd_t;

    // Status from datapath to controller
    typedef struct packed
    {
        logic out_valid;
        logic echo;
        logic label_start;
        logic label_last;
    } nrmc_stat_t;

    // Length of each label string
    function automatic logic [LBL_POS_W-1:0] label_len(input logic [LBL_IDX_W-1:0] idx);
        logic [LBL_POS_W-1:0] len;
        begin
            case (idx)
                4'd0:    len = 5'd21;
                4'd1:    len = 5'd15;
                4'd2:    len = 5'd12;
                4'd3:    len = 5'd13;
                4'd4:    len = 5'd13;
                4'd5:    len = 5'd13;
                4'd6:    len = 5'd18;
                4'd7:    len = 5'd22;
                4'd8:    len = 5'd20;
                4'd9:    len = 5'd22;
                4'd10:   len = 5'd13;
                default: len = 5'd1;
            endcase
            return len;
        end
    endfunction

    // Character k of label idx; strings sit right-aligned in the vector
    function automatic logic [7:0] label_byte(input logic [LBL_IDX_W-1:0] idx,
                                              input logic [LBL_POS_W-1:0] k);
        logic [LABEL_MAX_LEN*8-1:0] s;
        logic [LBL_POS_W-1:0]       pos;
        begin
            case (idx)
                4'd0:    s = "\n\rUTC Time (HhMmSs): ";
                4'd1:    s = "\n\rData Status: ";
                4'd2:    s = "\n\rLatitude: ";
                4'd3:    s = "\n\rDirection: ";
                4'd4:    s = "\n\rLongitude: ";
                4'd5:    s = "\n\rDirection: ";
                4'd6:    s = "\n\rSpeed in knots: ";
                4'd7:    s = "\n\rHeading in degrees: ";
                4'd8:    s = "\n\rDate UTC(DdMmAa): ";
                4'd9:    s = "\n\rMagnetic variation: ";
                4'd10:   s = "\n\rDirection: ";
                default: s = '0;
            endcase
            pos = label_len(idx) - 5'd1 - k;
            return s[pos*8 +: 8];
        end
    endfunction

endpackage

FILE: rtl/nmea_rmc_sentence_labeler.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_labeler
// Echoes matching NMEA sentences, replacing commas with field label strings.
// ----------------------------------------------------------------------------
// An echoed byte is registered and shows in the cycle after its item.
// Throughput: one item per cycle for echo or silent bytes; a comma that opens
// a label of L bytes (12 to 22) holds the input while the label table walk
// puts out its bytes, one byte per cycle. Output stall holds the input side too.
// Reset: asynchronous, returns to waiting for '$' and restores register defaults.
module nmea_rmc_sentence_labeler
#(
    parameter int LABEL_COUNT = nrmc_pkg::LABEL_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     tx_byte,
    output logic                           last_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nrmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    nrmc_pkg::nrmc_cmd_t  cmd;
    nrmc_pkg::nrmc_stat_t stat;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    nrmc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    nrmc_dp
    #(
        .LABEL_COUNT (LABEL_COUNT)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .out_stall   (out_stall),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .tx_byte     (tx_byte),
        .last_of_run (last_of_run)
    );

endmodule

FILE: rtl/nrmc_ctrl.sv
// ----------------------------------------------------------------------------
// nrmc_ctrl
// Controller: accepts items and sequences label bytes, one per unstalled cycle.
// ----------------------------------------------------------------------------
module nrmc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_stall,
    input  nrmc_pkg::nrmc_stat_t stat,
    output logic               in_stall,
    output nrmc_pkg::nrmc_cmd_t  cmd
);

    nrmc_pkg::nrmc_state_t state_reg;
    nrmc_pkg::nrmc_state_t state_next;
    logic                  out_free;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nrmc_pkg::ST_READY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register can take a byte when empty or being drained
    assign out_free = !stat.out_valid || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        cmd.accept     = 1'b0;
        cmd.load_echo  = 1'b0;
        cmd.load_label = 1'b0;
        case (state_reg)
            nrmc_pkg::ST_READY:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    cmd.accept    = 1'b1;
                    cmd.load_echo = stat.echo;
                    if (stat.label_start)
                    begin
                        state_next = nrmc_pkg::ST_LABEL;
                    end
                end
            end
            nrmc_pkg::ST_LABEL:
            begin
                if (out_free)
                begin
                    cmd.load_label = 1'b1;
                    if (stat.label_last)
                    begin
                        state_next = nrmc_pkg::ST_READY;
                    end
                end
            end
            default:
            begin
                state_next = nrmc_pkg::ST_READY;
            end
        endcase
    end

endmodule

FILE: rtl/nrmc_dp.sv
// ----------------------------------------------------------------------------
// nrmc_dp
// Datapath: sentence state, key match, label table walk and output register.
// ----------------------------------------------------------------------------
module nrmc_dp
#(
    parameter int LABEL_COUNT = nrmc_pkg::LABEL_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        rx_byte,
    input  logic                              out_stall,
    input  logic                              cfg_we,
    input  logic [nrmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data,
    input  nrmc_pkg::nrmc_cmd_t               cmd,
    output nrmc_pkg::nrmc_stat_t              stat,
    output logic                              out_valid,
    output logic [7:0]                        tx_byte,
    output logic                              last_of_run
);

    logic                             in_sentence_reg;
    logic [7:0]                       pos_reg;
    logic [7:0]                       sum_reg;
    logic [nrmc_pkg::LBL_IDX_W-1:0]   fcount_reg;
    logic [7:0]                       key_reg;
    logic [7:0]                       endc_reg;
    logic [nrmc_pkg::LBL_IDX_W-1:0]   lidx_reg;
    logic [nrmc_pkg::LBL_POS_W-1:0]   lk_reg;
    logic                             out_valid_reg;
    logic [7:0]                       tx_reg;
    logic                             last_reg;

    logic                             key_match;
    logic                             is_comma;
    logic                             label_avail;
    logic [nrmc_pkg::LBL_POS_W-1:0]   lk_final;

    // Decode the incoming byte against the sentence state
    assign key_match   = in_sentence_reg && (sum_reg == key_reg);
    assign is_comma    = (rx_byte == nrmc_pkg::CH_COMMA);
    assign label_avail = (32'(fcount_reg) < 32'(LABEL_COUNT))
                      && (32'(fcount_reg) < 32'(nrmc_pkg::ROM_LABELS));
    assign lk_final    = nrmc_pkg::label_len(lidx_reg) - 5'd1;

    assign stat.out_valid   = out_valid_reg;
    assign stat.echo        = key_match && !is_comma;
    assign stat.label_start = key_match && is_comma && label_avail;
    assign stat.label_last  = (lk_reg == lk_final);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= nrmc_pkg::KEY_RESET;
            endc_reg <= nrmc_pkg::END_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nrmc_pkg::REG_SENTENCE_KEY: key_reg  <= cfg_data;
                nrmc_pkg::REG_END_CODE:     endc_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Sentence tracking: position, type sum, label count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg <= 1'b0;
            pos_reg         <= '0;
            sum_reg         <= '0;
            fcount_reg      <= '0;
        end
        else if (cmd.accept)
        begin
            if (!in_sentence_reg)
            begin
                if (rx_byte == nrmc_pkg::CH_DOLLAR)
                begin
                    in_sentence_reg <= 1'b1;
                    pos_reg         <= pos_reg + 8'd1;
                end
            end
            else if (rx_byte == endc_reg)
            begin
                in_sentence_reg <= 1'b0;
                pos_reg         <= '0;
                sum_reg         <= '0;
                fcount_reg      <= '0;
            end
            else
            begin
                if (stat.label_start)
                begin
                    fcount_reg <= fcount_reg + 4'd1;
                end
                if ((pos_reg == 8'd4) || (pos_reg == 8'd5))
                begin
                    sum_reg <= sum_reg + rx_byte;
                end
                pos_reg <= pos_reg + 8'd1;
            end
        end
    end

    // Label walk pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lidx_reg <= '0;
            lk_reg   <= '0;
        end
        else if (cmd.accept && stat.label_start)
        begin
            lidx_reg <= fcount_reg;
            lk_reg   <= '0;
        end
        else if (cmd.load_label)
        begin
            lk_reg <= lk_reg + 5'd1;
        end
    end

    // Output register: load an echo or a label byte, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_echo || cmd.load_label)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_echo)
        begin
            tx_reg   <= rx_byte;
            last_reg <= 1'b1;
        end
        else if (cmd.load_label)
        begin
            tx_reg   <= nrmc_pkg::label_byte(lidx_reg, lk_reg);
            last_reg <= stat.label_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tx_byte     = tx_reg;
    assign last_of_run = last_reg;

endmodule

FILE: rtl/nrmc_chk.sv
// ----------------------------------------------------------------------------
// nrmc_chk
// Port-level checks for the RMC labeler, bound to the top level.
// ----------------------------------------------------------------------------
module nrmc_chk
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [7:0]                     rx_byte,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [7:0]                     tx_byte,
    input logic                           last_of_run,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [nrmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [7:0]                     cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last_of_run))
        else $error("stalled result changed");

    // Block new items while the output register is backed up
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("item accepted with output register full");

    // Keep input closed while a label is still running
    a_label_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |-> in_stall)
        else $error("item accepted in the middle of a label");

    // Keep the register port open
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind nmea_rmc_sentence_labeler nrmc_chk u_chk (.*);

FILE: bench/nmea_rmc_labeler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_rmc_labeler_checker
// Watches the byte, result and register channels of the RMC labeler, predicts
// the output bytes of every accepted item and compares them in order.
// ----------------------------------------------------------------------------
module nmea_rmc_labeler_checker
#(
    parameter int LABEL_COUNT = nrmc_pkg::LABEL_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     tx_byte,
    input  logic                           last_of_run,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [nrmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output int                             error_count,
    output int                             due_count,
    output int                             checked_count
);

    localparam int NUM_LABELS  = 11;
    localparam int LABEL_LIMIT = (LABEL_COUNT < NUM_LABELS) ? LABEL_COUNT : NUM_LABELS;

    typedef struct packed
    {
        logic [7:0] tx_byte;
        logic       last;
    } tx_beat_t;

    // Output bytes still owed by the block, oldest first
    tx_beat_t tx_due[$];

    // Shadow registers and sentence tracking state
    logic [7:0] key_reg;
    logic [7:0] end_reg;
    logic       in_sentence;
    logic [7:0] byte_pos;
    logic [7:0] type_sum;
    logic [3:0] labels_used;
    int         mismatches;
    int         beats_seen;

    // Field label text, one string per comma of an RMC sentence
    function automatic string field_label(input int idx);
        begin
            case (idx)
                0:       return "\n\rUTC Time (HhMmSs): ";
                1:       return "\n\rData Status: ";
                2:       return "\n\rLatitude: ";
                3:       return "\n\rDirection: ";
                4:       return "\n\rLongitude: ";
                5:       return "\n\rDirection: ";
                6:       return "\n\rSpeed in knots: ";
                7:       return "\n\rHeading in degrees: ";
                8:       return "\n\rDate UTC(DdMmAa): ";
                9:       return "\n\rMagnetic variation: ";
                10:      return "\n\rDirection: ";
                default: return "";
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what);
        begin
            $display("%0t ns mismatch: %s", $time, what);
            mismatches = mismatches + 1;
        end
    endtask

    // Advance the sentence state by one received byte and queue its output
    task automatic label_or_echo(input logic [7:0] b);
        string    text;
        tx_beat_t beat;
        int       k;
        begin
            if (!in_sentence)
            begin
                // Idle: only a dollar opens a sentence
                if (b == nrmc_pkg::CH_DOLLAR)
                begin
                    in_sentence = 1'b1;
                    byte_pos    = byte_pos + 8'd1;
                end
            end
            else
            begin
                if (type_sum == key_reg)
                begin
                    if (b == nrmc_pkg::CH_COMMA)
                    begin
                        // Swap the comma for the next label; drop it once all are used
                        if (int'(labels_used) < LABEL_LIMIT)
                        begin
                            text = field_label(int'(labels_used));
                            for (k = 0; k < text.len(); k++)
                            begin
                                beat.tx_byte = text.getc(k);
                                beat.last    = (k == text.len() - 1);
                                tx_due.push_back(beat);
                            end
                            labels_used = labels_used + 4'd1;
                        end
                    end
                    else
                    begin
                        beat.tx_byte = b;
                        beat.last    = 1'b1;
                        tx_due.push_back(beat);
                    end
                end
                if (byte_pos == 8'd4 || byte_pos == 8'd5)
                    type_sum = type_sum + b;
                byte_pos = byte_pos + 8'd1;
                if (b == end_reg)
                begin
                    in_sentence = 1'b0;
                    byte_pos    = 8'd0;
                    type_sum    = 8'd0;
                    labels_used = 4'd0;
                end
            end
        end
    endtask

    task automatic compare_beat;
        tx_beat_t want;
        begin
            beats_seen = beats_seen + 1;
            if (tx_due.size() == 0)
            begin
                report_mismatch($sformatf("byte %h out with nothing due", tx_byte));
            end
            else
            begin
                want = tx_due.pop_front();
                if (tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte got %h want %h", tx_byte, want.tx_byte));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run got %b want %b on byte %h",
                                              last_of_run, want.last, want.tx_byte));
            end
        end
    endtask

    // Sample all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       = nrmc_pkg::KEY_RESET;
            end_reg       = nrmc_pkg::END_RESET;
            in_sentence   = 1'b0;
            byte_pos      = 8'd0;
            type_sum      = 8'd0;
            labels_used   = 4'd0;
            mismatches    = 0;
            beats_seen    = 0;
            tx_due.delete();
            error_count   <= 0;
            due_count     <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == nrmc_pkg::REG_SENTENCE_KEY)
                    key_reg = cfg_data;
                else if (cfg_index == nrmc_pkg::REG_END_CODE)
                    end_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                label_or_echo(rx_byte);
            if (out_valid && !out_stall)
                compare_beat();
            error_count   <= mismatches;
            due_count     <= tx_due.size();
            checked_count <= beats_seen;
        end
    end

endmodule

FILE: bench/nmea_rmc_sentence_labeler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_labeler_tb
// Feeds NMEA-like byte streams through the labeler under several key and end
// code settings and idle patterns; the checker predicts and compares output.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_labeler_tb;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 14;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [7:0]                     rx_byte;
    logic                           out_valid;
    logic                           out_stall;
    logic [7:0]                     tx_byte;
    logic                           last_of_run;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [nrmc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;

    int         error_count;
    int         due_count;
    int         checked_count;
    int         idle_pct;
    int         stall_pct;
    int         items_sent;
    logic [7:0] key_now;
    logic [7:0] end_now;

    nmea_rmc_sentence_labeler dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    nmea_rmc_labeler_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_byte       (tx_byte),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .due_count     (due_count),
        .checked_count (checked_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Random output stall at the current pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hand one item over, idling first at the current rate
    task automatic send_byte(input logic [7:0] b);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte  <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent = items_sent + 1;
        end
    endtask

    // Write both registers back to back, holding valid across them
    task automatic write_regs(input logic [7:0] key, input logic [7:0] endc);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= nrmc_pkg::REG_SENTENCE_KEY;
            cfg_data  <= key;
            do @(posedge clk); while (!cfg_ready);
            cfg_index <= nrmc_pkg::REG_END_CODE;
            cfg_data  <= endc;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            key_now = key;
            end_now = endc;
        end
    endtask

    // Drop valid and wait until every owed byte has come out
    task automatic settle;
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (due_count != 0);
            repeat (4) @(posedge clk);
        end
    endtask

    // One sentence: header, type letters, body with commas, optional end code
    task automatic send_sentence(input int body_len, input bit type_ok, input bit close_it);
        logic [7:0] first_letter;
        logic [7:0] ch;
        int         k;
        begin
            send_byte(nrmc_pkg::CH_DOLLAR);
            send_byte("G");
            send_byte("P");
            send_byte("R");
            first_letter = 8'(65 + $urandom_range(25));
            send_byte(first_letter);
            if (type_ok)
                send_byte(8'(key_now - first_letter));
            else
                send_byte(8'(65 + $urandom_range(25)));
            for (k = 0; k < body_len; k++)
            begin
                if ($urandom_range(3) == 0)
                    ch = nrmc_pkg::CH_COMMA;
                else if ($urandom_range(15) == 0)
                    ch = 8'($urandom_range(255));
                else
                    ch = 8'($urandom_range(8'h7E, 8'h20));
                // Keep the body from closing the sentence early
                if (ch == end_now)
                    ch = ch ^ 8'h01;
                send_byte(ch);
            end
            if (close_it)
                send_byte(end_now);
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int phase;
        int start_items;
        int pick;
        int room;
        int k;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rx_byte        = 8'h00;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = nrmc_pkg::REG_SENTENCE_KEY;
        cfg_data       = 8'h00;
        idle_pct       = 0;
        stall_pct      = 0;
        items_sent     = 0;
        key_now        = nrmc_pkg::KEY_RESET;
        end_now        = nrmc_pkg::END_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Pick the register setting for this phase
            case (phase)
                0, 1:    write_regs(nrmc_pkg::KEY_RESET, nrmc_pkg::END_RESET);
                2:       write_regs(8'd0, 8'd255);
                3:       write_regs(8'd255, 8'd0);
                4:       write_regs(nrmc_pkg::KEY_RESET, nrmc_pkg::CH_COMMA);
                6:       write_regs(nrmc_pkg::KEY_RESET, nrmc_pkg::END_RESET);
                default: write_regs(8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase

            // Rotate the idle and stall pattern
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase

            if (phase == 0)
            begin
                // Idle noise at both extremes, then a matching sentence that
                // runs past the last label and echoes both extremes
                send_byte(8'hFF);
                send_byte(8'h00);
                send_byte(nrmc_pkg::CH_DOLLAR);
                send_byte("G");
                send_byte("P");
                send_byte("R");
                send_byte("M");
                send_byte("C");
                for (k = 0; k < 12; k++)
                    send_byte(nrmc_pkg::CH_COMMA);
                send_byte(8'h00);
                send_byte(8'hFF);
                send_byte(nrmc_pkg::END_RESET);
            end

            if (phase == 6)
            begin
                // Long sentence so the position counter wraps past the type bytes
                send_sentence(262, 1'b1, 1'b1);
            end

            // Random traffic until the phase budget is spent; bodies shrink to fit
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS)
            begin
                room = PHASE_ITEMS - (items_sent - start_items);
                pick = $urandom_range(99);
                if (pick < 72)
                    send_sentence(int'($urandom_range(room)), 1'b1, 1'b1);
                else if (pick < 80)
                    send_sentence(int'($urandom_range(room)), 1'b0, 1'b1);
                else if (pick < 86)
                    send_sentence(int'($urandom_range(room)), 1'b1, 1'b0);
                else
                begin
                    // Line noise between sentences
                    for (k = $urandom_range(4, 1); k > 0; k--)
                        send_byte(8'($urandom_range(255)));
                end
            end
            settle();
        end

        repeat (25) @(posedge clk);
        $display("run: %0d input items under %0d register settings, %0d output bytes checked",
                 items_sent, PHASES, checked_count);
        $display("run: label overrun, early key match, comma end code and position wrap hit");
        if (error_count == 0 && due_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
